// ===== rtl/accel_tilt_vertical_detector_assert.svh =====
// Assertion macros for the tilt detector.
`ifndef ACCEL_TILT_VERTICAL_DETECTOR_ASSERT_SVH
`define ACCEL_TILT_VERTICAL_DETECTOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ATVD_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ATVD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== rtl/atvd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package atvd_pkg;
  localparam int TABLE_LEN = 24;
  localparam int INT_FRAC = 20;
  // The CORDIC works on inputs times 2^16 plus growth; 36 bits hold that.
  localparam int CW = 36;
  localparam int ZW = 30;
  localparam logic [ZW-1:0] DEG180 = ZW'(180 * (1 << INT_FRAC));
  localparam int OUT_LIMIT = 32767;

  localparam logic [1:0] REG_LOW = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic sample_ignored;
    logic is_vertical;
    logic report_valid;
    logic report_event;
  } out_item_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_DONE
  } cordic_state_t;

  function automatic logic [ZW-1:0] atan_tab(input logic [4:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      5'd0: v = ZW'(47185920);
      5'd1: v = ZW'(27855475);
      5'd2: v = ZW'(14718068);
      5'd3: v = ZW'(7471121);
      5'd4: v = ZW'(3750058);
      5'd5: v = ZW'(1876857);
      5'd6: v = ZW'(938658);
      5'd7: v = ZW'(469357);
      5'd8: v = ZW'(234682);
      5'd9: v = ZW'(117342);
      5'd10: v = ZW'(58671);
      5'd11: v = ZW'(29335);
      5'd12: v = ZW'(14668);
      5'd13: v = ZW'(7334);
      5'd14: v = ZW'(3667);
      5'd15: v = ZW'(1833);
      5'd16: v = ZW'(917);
      5'd17: v = ZW'(458);
      5'd18: v = ZW'(229);
      5'd19: v = ZW'(115);
      5'd20: v = ZW'(57);
      5'd21: v = ZW'(29);
      5'd22: v = ZW'(14);
      5'd23: v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/atvd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accepts samples into a two-entry queue; ignored samples are flagged here.
module atvd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire atvd_pkg::in_item_t in_data,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output atvd_pkg::in_item_t      q_data,
  output logic                    q_ignored
);
  atvd_pkg::in_item_t mem_r [2];
  logic ign_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_data = mem_r[rp_r];
  assign q_ignored = ign_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
      ign_r[wp_r] <= (in_data.accel_y == 16'sd0) && (in_data.accel_z == 16'sd0);
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/atvd_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Iterative vectoring CORDIC: atan2(num, den) in output angle units.
module atvd_cordic #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] num,
  input  wire logic signed [15:0] den,
  output logic                    done,
  output logic signed [15:0]      angle
);
  localparam int STEPS = (CORDIC_STEPS < atvd_pkg::TABLE_LEN) ?
                         CORDIC_STEPS : atvd_pkg::TABLE_LEN;
  localparam int SH = atvd_pkg::INT_FRAC - ANGLE_FRAC_BITS;
  localparam int CW = atvd_pkg::CW;
  localparam int ZW = atvd_pkg::ZW;

  atvd_pkg::cordic_state_t st_r, st_nxt;
  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic zero_r, zero_nxt;
  logic signed [CW-1:0] xs, ys, nx0, ny0;
  logic signed [ZW-1:0] rnd, mag;
  logic signed [ZW-1:0] q;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;

  always_comb begin
    st_nxt = st_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    zero_nxt = zero_r;
    nx0 = CW'(den) <<< 16;
    ny0 = CW'(num) <<< 16;
    unique case (st_r)
      atvd_pkg::CS_IDLE: begin
        if (start) begin
          zero_nxt = (num == 16'sd0) && (den == 16'sd0);
          i_nxt = '0;
          if (den < 0) begin
            x_nxt = -nx0;
            y_nxt = -ny0;
            z_nxt = (num >= 0) ? atvd_pkg::DEG180 : -atvd_pkg::DEG180;
          end else begin
            x_nxt = nx0;
            y_nxt = ny0;
            z_nxt = '0;
          end
          st_nxt = atvd_pkg::CS_RUN;
        end
      end
      atvd_pkg::CS_RUN: begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atvd_pkg::atan_tab(i_r);
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atvd_pkg::atan_tab(i_r);
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(STEPS - 1)) st_nxt = atvd_pkg::CS_DONE;
      end
      atvd_pkg::CS_DONE: st_nxt = atvd_pkg::CS_IDLE;
      default: st_nxt = atvd_pkg::CS_IDLE;
    endcase
  end

  // Round half away from zero, then saturate.
  always_comb begin
    mag = (z_r < 0) ? -z_r : z_r;
    rnd = (mag + ZW'(1 << (SH - 1))) >>> SH;
    if (rnd > ZW'(atvd_pkg::OUT_LIMIT)) rnd = ZW'(atvd_pkg::OUT_LIMIT);
    q = (z_r < 0) ? -rnd : rnd;
  end

  assign done = (st_r == atvd_pkg::CS_DONE);
  assign angle = zero_r ? 16'sd0 : q[15:0];

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    zero_r <= zero_nxt;
    if (!rst_n) st_r <= atvd_pkg::CS_IDLE;
    else st_r <= st_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/atvd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Computes both angles, runs the vertical state, holds the result register.
module atvd_back #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire atvd_pkg::in_item_t q_data,
  input  wire logic               q_ignored,
  input  wire logic [14:0]        low_thr,
  input  wire logic [14:0]        high_thr,
  input  wire logic [7:0]         enter_cnt,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output atvd_pkg::out_item_t     out_data,
  output logic                    vertical
);
  logic busy_r;
  logic out_valid_r;
  atvd_pkg::out_item_t out_r;
  logic vert_r;
  logic [7:0] qcnt_r;
  logic start, p_done, r_done, done_both;
  logic signed [15:0] p_ang, r_ang, pitch;
  logic [7:0] inc, need;
  logic qual, enter, leave;

  function automatic logic band(input logic signed [15:0] a,
                                input logic [14:0] lo, input logic [14:0] hi);
    logic [15:0] m;
    m = a[15] ? 16'(-a) : 16'(a);
    return (m > {1'b0, lo}) && (m < {1'b0, hi});
  endfunction

  // Take a new sample only once both angle units are idle and the result register is free.
  assign q_ready = !busy_r && !out_valid_r;
  assign start = q_valid && q_ready && !q_ignored;

  atvd_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk, .rst_n, .start, .num(q_data.accel_y), .den(q_data.accel_z),
    .done(p_done), .angle(p_ang));
  atvd_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk, .rst_n, .start, .num(q_data.accel_x), .den(q_data.accel_z),
    .done(r_done), .angle(r_ang));

  // Both units start together and always finish together.
  assign done_both = p_done && r_done;

  assign pitch = -p_ang;
  assign qual = band(pitch, low_thr, high_thr) || band(r_ang, low_thr, high_thr);
  assign inc = qcnt_r + 8'd1;
  assign need = (enter_cnt == 8'd0) ? 8'd1 : enter_cnt;
  assign enter = qual && !vert_r && (inc >= need);
  assign leave = !qual && vert_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign vertical = vert_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_ignored) begin
      out_r <= '{pitch_angle: '0, roll_angle: '0, sample_ignored: 1'b1,
                 is_vertical: vert_r, report_valid: 1'b0, report_event: 1'b0};
    end else if (done_both) begin
      out_r <= '{pitch_angle: pitch, roll_angle: r_ang, sample_ignored: 1'b0,
                 is_vertical: enter || (vert_r && qual), report_valid: enter || leave,
                 report_event: leave};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
      vert_r <= 1'b0;
      qcnt_r <= 8'd0;
    end else begin
      if (start) busy_r <= 1'b1;
      if (done_both) busy_r <= 1'b0;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if ((q_valid && q_ready && q_ignored) || done_both) out_valid_r <= 1'b1;
      if (done_both) begin
        if (qual) begin
          if (!vert_r) begin
            if (inc >= need) begin
              qcnt_r <= 8'd0;
              vert_r <= 1'b1;
            end else begin
              qcnt_r <= inc;
            end
          end
        end else begin
          qcnt_r <= 8'd0;
          vert_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/accel_tilt_vertical_detector.sv =====
// Path: a sample passes from the input queue through both angle units into the
// result register; an ignored sample (y and z zero) goes straight to that register.
// Flow: a new sample enters the angle units only once the previous result has left
// the result register; a two-entry input queue absorbs bursts.
// Reset (rst_n low, synchronous): thresholds 7680 / 15360, enter count 5,
// non-vertical state, count zero, queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none
`include "accel_tilt_vertical_detector_assert.svh"
module accel_tilt_vertical_detector #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire atvd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output atvd_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [14:0]         cfg_wdata
);
  logic [14:0] low_r, high_r;
  logic [7:0] cnt_r;
  logic q_valid, q_ready, q_ignored, vertical;
  atvd_pkg::in_item_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= 15'd7680;
      high_r <= 15'd15360;
      cnt_r <= 8'd5;
    end else if (cfg_we) begin
      if (cfg_index == atvd_pkg::REG_LOW) low_r <= cfg_wdata;
      if (cfg_index == atvd_pkg::REG_HIGH) high_r <= cfg_wdata;
      if (cfg_index == atvd_pkg::REG_COUNT) cnt_r <= cfg_wdata[7:0];
    end
  end

  atvd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data, .q_ignored);

  atvd_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .q_ignored,
    .low_thr(low_r), .high_thr(high_r), .enter_cnt(cnt_r),
    .out_valid, .out_ready, .out_data, .vertical);

  `ATVD_ASSERT_IMP(a_evt, clk, rst_n, out_valid && !out_data.report_valid,
    !out_data.report_event, "event kind set without a report")
  `ATVD_ASSERT_IMP(a_ign, clk, rst_n, out_valid && out_data.sample_ignored,
    !out_data.report_valid && out_data.pitch_angle == 16'sd0, "ignored sample reported")
  `ATVD_ASSERT_IMP(a_state, clk, rst_n, out_valid, out_data.is_vertical == vertical,
    "result state differs from detector state")
endmodule
`default_nettype wire

// ===== tb/atvd_checker.sv =====
`timescale 1ns / 1ps
module atvd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  atvd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  atvd_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_wdata,
  output int                  fail_count,
  output int                  pending
);
  import atvd_pkg::*;

  localparam int FRAC = 7;
  localparam int STEPS = 16;
  localparam longint HALF_TURN = 180 * (64'sd1 << 20);

  // Angle step table in 2^-20 degree units.
  localparam longint ARC_STEP [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7};

  logic [14:0] lo_thr, hi_thr;
  logic [7:0]  run_needed, run_len;
  logic        upright;
  out_item_t   expected_results[$];

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int tilt_angle(int num, int den);
    longint x, y, z, nx, r;
    int sh;
    if (num == 0 && den == 0) return 0;
    x = longint'(den) * 65536;
    y = longint'(num) * 65536;
    z = 0;
    if (den < 0) begin
      z = (num >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (y >= 0) begin
        nx = x + floor_sh(y, i);
        y = y - floor_sh(x, i);
        z += ARC_STEP[i];
      end else begin
        nx = x - floor_sh(y, i);
        y = y + floor_sh(x, i);
        z -= ARC_STEP[i];
      end
      x = nx;
    end
    sh = 20 - FRAC;
    if (z >= 0) r = (z + (64'sd1 << (sh - 1))) >>> sh;
    else r = -((-z + (64'sd1 << (sh - 1))) >>> sh);
    if (r > OUT_LIMIT) r = OUT_LIMIT;
    if (r < -OUT_LIMIT) r = -OUT_LIMIT;
    return int'(r);
  endfunction

  function automatic bit in_band(int a);
    int m;
    m = a < 0 ? -a : a;
    return m > int'(lo_thr) && m < int'(hi_thr);
  endfunction

  function automatic out_item_t tilt_result(in_item_t s);
    out_item_t o;
    int p, r;
    logic [7:0] need;
    o = '0;
    if (s.accel_y == 0 && s.accel_z == 0) begin
      o.sample_ignored = 1'b1;
    end else begin
      p = -tilt_angle(s.accel_y, s.accel_z);
      r = tilt_angle(s.accel_x, s.accel_z);
      o.pitch_angle = 16'(p);
      o.roll_angle = 16'(r);
      need = run_needed;
      if (in_band(p) || in_band(r)) begin
        if (!upright) begin
          run_len = run_len + 8'd1;
          if (run_len >= need) begin
            run_len = '0;
            upright = 1'b1;
            o.report_valid = 1'b1;
          end
        end
      end else begin
        run_len = '0;
        if (upright) begin
          upright = 1'b0;
          o.report_valid = 1'b1;
          o.report_event = 1'b1;
        end
      end
    end
    o.is_vertical = upright;
    return o;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      lo_thr <= 15'd7680;
      hi_thr <= 15'd15360;
      run_needed <= 8'd5;
      run_len = '0;
      upright = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LOW: lo_thr <= cfg_wdata;
          REG_HIGH: hi_thr <= cfg_wdata;
          REG_COUNT: run_needed <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(tilt_result(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_accel_tilt_vertical_detector.sv =====
`timescale 1ns / 1ps
module tb_accel_tilt_vertical_detector;
  import atvd_pkg::*;

  // An index that maps to no register.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_wdata = '0;
  int fail_count, pending;
  bit calm = 1'b0;
  int hold_off = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  accel_tilt_vertical_detector dut (.*);

  atvd_checker u_checker (.*);

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // Valid may stay high from the previous transfer when the next one follows at once.
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{accel_x: x, accel_y: y, accel_z: z};
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  // Mostly samples tilted toward the detection band, with random, ignored and near-zero ones mixed in.
  task automatic send_random();
    int k;
    logic [15:0] a, b;
    k = $urandom_range(9);
    a = 16'($urandom_range(30000, 1));
    b = 16'($urandom_range(30000, 1));
    if (k < 2) send_sample(16'($urandom), 16'($urandom), 16'($urandom));
    else if (k == 2) send_sample(16'($urandom), 16'd0, 16'd0);
    else if (k == 3) send_sample(16'($urandom), 16'($urandom_range(3) - 1),
                                 16'($urandom_range(3) - 1));
    else if (k < 7) send_sample(16'($urandom_range(200)), $urandom_range(1) ? a : -a, b);
    else send_sample($urandom_range(1) ? a : -a, 16'($urandom_range(200)), b);
  endtask

  initial begin
    #50_000_000;
    $display("accel_tilt_vertical_detector verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: extremes, ignored samples, zero operands, quadrants.
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h1234, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0001, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'hFFFF);
    for (int i = 0; i < 7; i++) send_sample(16'd0, 16'd1000, 16'd1000);
    send_sample(16'd0, 16'd0, 16'd1000);
    send_sample(16'hFFFF, 16'hFFFF, 16'h0001);
    drain();
    write_reg(REG_COUNT, 15'h7F00);
    send_sample(16'd0, 16'd1000, 16'd1000);
    send_sample(16'd0, 16'd1000, 16'd1000);
    drain();
    write_reg(REG_LOW, 15'd0);
    write_reg(REG_HIGH, 15'd23040);
    write_reg(REG_UNUSED, 15'h7FFF);
    send_sample(16'd5, 16'd7, 16'd9);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_LOW, 15'd7680); write_reg(REG_HIGH, 15'd15360);
          write_reg(REG_COUNT, 15'd1); end
        1: begin write_reg(REG_LOW, 15'd23040); write_reg(REG_HIGH, 15'd0); end
        2: begin write_reg(REG_LOW, 15'($urandom_range(11520))); write_reg(REG_HIGH,
          15'($urandom_range(23040, 11520))); write_reg(REG_COUNT,
          15'($urandom_range(8, 2))); end
        3: begin write_reg(REG_COUNT, 15'd255); write_reg(REG_LOW, 15'd0); end
        4: begin write_reg(REG_COUNT, 15'd3); write_reg(REG_LOW, 15'd2000);
          write_reg(REG_HIGH, 15'd21000); end
        default: begin write_reg(REG_LOW, 15'd7680); write_reg(REG_HIGH, 15'd15360);
          write_reg(REG_COUNT, 15'd5); end
      endcase
      calm = (phase == 4);
      if (phase == 2) hold_off = 400;
      for (int i = 0; i < 172; i++) send_random();
      calm = 1'b0;
      drain();
    end
    if (fail_count == 0) begin
      $display("accel_tilt_vertical_detector verification clean");
    end else begin
      $display("accel_tilt_vertical_detector verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/atvd_pkg.sv
rtl/atvd_front.sv
rtl/atvd_cordic.sv
rtl/atvd_back.sv
rtl/accel_tilt_vertical_detector.sv
tb/atvd_checker.sv
tb/tb_accel_tilt_vertical_detector.sv
